// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/lsss_pkg.sv =====
// ----------------------------------------------------------------------------
// lsss_pkg
// Shared types and constants for the line segment set statistics block.
// ----------------------------------------------------------------------------
package lsss_pkg;

    localparam int ANG_FRAC     = 24;
    localparam int CORDIC_STEPS = 24;
    localparam int TAB_IW       = 5;

    // degrees with ANG_FRAC fraction bits
    localparam logic [31:0] ANG_90  = 32'd1509949440;
    localparam logic [31:0] ANG_180 = 32'd3019898880;

    // result field widths
    localparam int CNT_OW = 11;
    localparam int MX_OW  = 16;
    localparam int MY_OW  = 16;
    localparam int LEN_OW = 17;
    localparam int ANG_OW = 12;

    typedef struct packed {
        logic has_seg;
        logic last;
        logic neg;      // y_start < y_end, angle folds to 180 - theta
    } t_seg_flags;

    typedef logic [31:0] t_atan_tab [CORDIC_STEPS];

    localparam t_atan_tab ATAN_TAB = '{
        32'd754974720, 32'd445687602, 32'd235489089, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234684,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115
    };

endpackage

// ===== sv/lsss_front.sv =====
// ----------------------------------------------------------------------------
// lsss_front
// Accepts segment words and reduces them to midpoints, absolute deltas
// and flags for the queue.
// ----------------------------------------------------------------------------
module lsss_front #(
    parameter int CW = 12
) (
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [CW-1:0]         i_x_start,
    input  logic [CW-1:0]         i_y_start,
    input  logic [CW-1:0]         i_x_end,
    input  logic [CW-1:0]         i_y_end,
    input  logic                  i_has_segment,
    input  logic                  i_last,
    input  logic                  i_full,
    output logic                  o_push,
    output logic [CW-1:0]         o_mid_x,
    output logic [CW-1:0]         o_mid_y,
    output logic [CW-1:0]         o_adx,
    output logic [CW-1:0]         o_ady,
    output lsss_pkg::t_seg_flags  o_flags
);
    import lsss_pkg::*;

    logic [CW:0] sum_x;
    logic [CW:0] sum_y;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    assign sum_x   = {1'b0, i_x_start} + {1'b0, i_x_end};
    assign sum_y   = {1'b0, i_y_start} + {1'b0, i_y_end};
    assign o_mid_x = sum_x[CW:1];
    assign o_mid_y = sum_y[CW:1];

    assign o_adx = (i_x_end >= i_x_start) ? i_x_end - i_x_start : i_x_start - i_x_end;
    assign o_ady = (i_y_start >= i_y_end) ? i_y_start - i_y_end : i_y_end - i_y_start;

    assign o_flags.has_seg = i_has_segment;
    assign o_flags.last    = i_last;
    assign o_flags.neg     = i_y_start < i_y_end;

endmodule

// ===== sv/lsss_fifo.sv =====
// ----------------------------------------------------------------------------
// lsss_fifo
// Four-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module lsss_fifo #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [DW-1:0] o_data
);
    import lsss_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    logic [DW-1:0] r_mem [DEPTH];
    logic [PW:0]   r_wr;
    logic [PW:0]   r_rd;

    assign o_empty = r_wr == r_rd;
    assign o_full  = (r_wr[PW] != r_rd[PW]) && (r_wr[PW-1:0] == r_rd[PW-1:0]);
    assign o_data  = r_mem[r_rd[PW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr[PW-1:0]] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

endmodule

// ===== sv/lsss_back.sv =====
// ----------------------------------------------------------------------------
// lsss_back
// Per-segment length (bit-serial square root) and angle (CORDIC), running
// sums, and serial division of the sums on the closing word.
// ----------------------------------------------------------------------------
module lsss_back #(
    parameter int CW           = 12,
    parameter int MAX_SEGMENTS = 1024,
    parameter int FRAC_BITS    = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    output logic                          o_pop,
    input  logic [CW-1:0]                 i_mid_x,
    input  logic [CW-1:0]                 i_mid_y,
    input  logic [CW-1:0]                 i_adx,
    input  logic [CW-1:0]                 i_ady,
    input  lsss_pkg::t_seg_flags          i_flags,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [lsss_pkg::CNT_OW-1:0]   o_count,
    output logic                          o_found,
    output logic [lsss_pkg::MX_OW-1:0]    o_mean_mid_x,
    output logic [lsss_pkg::MY_OW-1:0]    o_mean_mid_y,
    output logic [lsss_pkg::LEN_OW-1:0]   o_mean_length,
    output logic [lsss_pkg::ANG_OW-1:0]   o_mean_angle,
    output logic                          o_overflowed
);
    import lsss_pkg::*;

    localparam int CNTW   = $clog2(MAX_SEGMENTS + 1);
    localparam int SQW    = (2 * CW + 2 + 2 * FRAC_BITS) / 2;
    localparam int RADW   = 2 * SQW;
    localparam int XW     = CW + ANG_FRAC + 3;
    localparam int AW     = 8 + FRAC_BITS;
    localparam int SMW    = CW + CNTW;
    localparam int SLW    = SQW + CNTW;
    localparam int SAW    = AW + CNTW;
    localparam int DV0    = (SMW + FRAC_BITS > SLW) ? SMW + FRAC_BITS : SLW;
    localparam int DW     = (DV0 > SAW) ? DV0 : SAW;
    localparam int DSW    = $clog2(DW);
    localparam int LOOP_N = (SQW > CORDIC_STEPS) ? SQW : CORDIC_STEPS;
    localparam int ITW    = $clog2(LOOP_N);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SQR  = 6'b000010,
        S_ITER = 6'b000100,
        S_ACC  = 6'b001000,
        S_WAIT = 6'b010000,
        S_DIV  = 6'b100000
    } t_state;

    t_state r_state;

    logic [CW-1:0]   r_mid_x, r_mid_y, r_adx, r_ady;
    t_seg_flags      r_flags;
    logic [CNTW-1:0] r_cnt;
    logic [SMW-1:0]  r_sum_mx, r_sum_my;
    logic [SLW-1:0]  r_sum_len;
    logic [SAW-1:0]  r_sum_ang;
    logic            r_drop;

    logic [RADW-1:0]        r_rad;
    logic [SQW+1:0]         r_rem;
    logic [SQW-1:0]         r_root;
    logic signed [XW-1:0]   r_x, r_y;
    logic signed [31:0]     r_z;
    logic [ITW-1:0]         r_i;

    logic [DW-1:0]   r_dvd;
    logic [CNTW-1:0] r_drem;
    logic [DSW-1:0]  r_dstep;
    logic [1:0]      r_dsel;
    logic            r_ovalid;

    // square-root step
    logic [SQW+1:0] sq_sh, sq_trial;
    logic [2*CW:0]  d2;
    // cordic step
    logic signed [XW-1:0] xs, ys;
    logic [31:0]          atan_v;
    // accumulate
    logic [30:0] theta;
    logic [31:0] ang;
    logic [AW-1:0] angv;
    // divide step
    logic [CNTW:0]   dv_sh;
    logic            dv_q;
    logic [DW-1:0]   quot;
    logic [DW-1:0]   next_dvd;
    logic            full;
    logic            res_done;

    assign full  = r_cnt >= CNTW'(MAX_SEGMENTS);
    assign o_pop = (r_state == S_IDLE) && !i_empty;

    // result word completes: empty set at once, else after the last division
    assign res_done = ((r_state == S_WAIT) && (!r_ovalid || i_ready) && (r_cnt == '0))
                   || ((r_state == S_DIV) && (int'(r_dstep) == DW - 1) && (r_dsel == 2'd3));

    assign d2 = (2*CW+1)'(r_adx * r_adx) + (2*CW+1)'(r_ady * r_ady);

    assign sq_sh    = {r_rem[SQW-1:0], r_rad[RADW-1 -: 2]};
    assign sq_trial = {r_root, 2'b01};

    assign xs     = r_x >>> r_i;
    assign ys     = r_y >>> r_i;
    assign atan_v = ATAN_TAB[r_i[TAB_IW-1:0]];

    always_comb begin
        if (r_ady == '0) begin
            theta = '0;
        end else if (r_adx == '0) begin
            theta = ANG_90[30:0];
        end else if (r_z < 0) begin
            theta = '0;
        end else if (r_z > $signed(ANG_90)) begin
            theta = ANG_90[30:0];
        end else begin
            theta = r_z[30:0];
        end
        ang  = r_flags.neg ? ANG_180 - {1'b0, theta} : {1'b0, theta};
        angv = AW'(ang >> (ANG_FRAC - FRAC_BITS));
    end

    assign dv_sh = {r_drem, r_dvd[DW-1]};
    assign dv_q  = dv_sh >= {1'b0, r_cnt};
    assign quot  = {r_dvd[DW-2:0], dv_q};

    always_comb begin
        case (r_dsel)
            2'd0:    next_dvd = DW'({r_sum_my, FRAC_BITS'(0)});
            2'd1:    next_dvd = DW'(r_sum_len);
            default: next_dvd = DW'(r_sum_ang);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mid_x <= i_mid_x;
            r_mid_y <= i_mid_y;
            r_adx   <= i_adx;
            r_ady   <= i_ady;
            r_flags <= i_flags;
        end
        if (r_state == S_SQR) begin
            r_rad  <= RADW'(d2) << (2 * FRAC_BITS);
            r_rem  <= '0;
            r_root <= '0;
            r_x    <= $signed(XW'(r_adx)) <<< ANG_FRAC;
            r_y    <= $signed(XW'(r_ady)) <<< ANG_FRAC;
            r_z    <= '0;
        end
        if (r_state == S_ITER) begin
            if (int'(r_i) < SQW) begin
                r_rad <= r_rad << 2;
                if (sq_sh >= sq_trial) begin
                    r_rem  <= sq_sh - sq_trial;
                    r_root <= {r_root[SQW-2:0], 1'b1};
                end else begin
                    r_rem  <= sq_sh;
                    r_root <= {r_root[SQW-2:0], 1'b0};
                end
            end
            if (int'(r_i) < CORDIC_STEPS) begin
                if (r_y > 0) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + $signed(atan_v);
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - $signed(atan_v);
                end
            end
        end
        if (r_state == S_WAIT) begin
            r_dvd   <= DW'({r_sum_mx, FRAC_BITS'(0)});
            r_drem  <= '0;
            r_dstep <= '0;
        end
        if (r_state == S_DIV) begin
            if (int'(r_dstep) == DW - 1) begin
                r_dvd   <= next_dvd;
                r_drem  <= '0;
                r_dstep <= '0;
                case (r_dsel)
                    2'd0:    o_mean_mid_x  <= MX_OW'(quot);
                    2'd1:    o_mean_mid_y  <= MY_OW'(quot);
                    2'd2:    o_mean_length <= LEN_OW'(quot);
                    default: o_mean_angle  <= ANG_OW'(quot);
                endcase
            end else begin
                r_drem  <= dv_q ? CNTW'(dv_sh - {1'b0, r_cnt}) : CNTW'(dv_sh);
                r_dvd   <= quot;
                r_dstep <= r_dstep + 1'b1;
            end
        end
        if (r_state == S_WAIT && (!r_ovalid || i_ready)) begin
            o_count      <= CNT_OW'(r_cnt);
            o_found      <= r_cnt != '0;
            o_overflowed <= r_drop;
            if (r_cnt == '0) begin
                o_mean_mid_x  <= '0;
                o_mean_mid_y  <= '0;
                o_mean_length <= '0;
                o_mean_angle  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_sum_mx  <= '0;
            r_sum_my  <= '0;
            r_sum_len <= '0;
            r_sum_ang <= '0;
            r_drop    <= 1'b0;
            r_i       <= '0;
            r_dsel    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (res_done) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        if (i_flags.has_seg && !full) begin
                            r_state <= S_SQR;
                        end else begin
                            if (i_flags.has_seg) begin
                                r_drop <= 1'b1;
                            end
                            r_state <= i_flags.last ? S_WAIT : S_IDLE;
                        end
                    end
                end
                S_SQR: begin
                    r_i     <= '0;
                    r_state <= S_ITER;
                end
                S_ITER: begin
                    r_i <= r_i + 1'b1;
                    if (int'(r_i) == LOOP_N - 1) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_sum_mx  <= r_sum_mx + SMW'(r_mid_x);
                    r_sum_my  <= r_sum_my + SMW'(r_mid_y);
                    r_sum_len <= r_sum_len + SLW'(r_root);
                    r_sum_ang <= r_sum_ang + SAW'(angv);
                    r_cnt     <= r_cnt + 1'b1;
                    r_state   <= r_flags.last ? S_WAIT : S_IDLE;
                end
                S_WAIT: begin
                    if (!r_ovalid || i_ready) begin
                        r_dsel <= '0;
                        if (r_cnt == '0) begin
                            r_drop   <= 1'b0;
                            r_state  <= S_IDLE;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (int'(r_dstep) == DW - 1) begin
                        r_dsel <= r_dsel + 1'b1;
                        if (r_dsel == 2'd3) begin
                            r_cnt     <= '0;
                            r_sum_mx  <= '0;
                            r_sum_my  <= '0;
                            r_sum_len <= '0;
                            r_sum_ang <= '0;
                            r_drop    <= 1'b0;
                            r_state   <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;

endmodule

// ===== sv/line_segment_set_statistics.sv =====
// ----------------------------------------------------------------------------
// line_segment_set_statistics
// Running statistics over a set of line segments: count, mean midpoint,
// mean length and mean angle, reported on the closing word.
// ----------------------------------------------------------------------------
// channel | direction | tdata                            | tuser / tlast
// s_axis  | in        | x_start,y_start,x_end,y_end      | has_segment / last
// m_axis  | out       | count,mid_x,mid_y,length,angle   | found,overflowed
//
// In the back part a segment is popped, set up, iterated (CORDIC and square
// root iterate together) and accumulated before the next one is popped.
// The closing word adds four serial divisions, one quotient bit a cycle.
// Reset is synchronous, active low; no clearing pass is needed.
// A four-word queue lets input words in while the back part iterates, and
// the result register lets the next set start while a result stalls.
module line_segment_set_statistics #(
    parameter int COORD_BITS   = 12,
    parameter int MAX_SEGMENTS = 1024,
    parameter int FRAC_BITS    = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // x_start, y_start, x_end, y_end, zero fill
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // has_segment
    input  logic                           s_axis_tuser,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // segment_count, mean_mid_x, mean_mid_y, mean_length, mean_angle
    output logic [71:0]                    m_axis_tdata,
    // found, overflowed
    output logic [1:0]                     m_axis_tuser
);
    import lsss_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int QW = 4 * CW + $bits(t_seg_flags);

    logic            push, full, pop, empty;
    logic [CW-1:0]   f_mid_x, f_mid_y, f_adx, f_ady;
    t_seg_flags      f_flags, b_flags;
    logic [QW-1:0]   q_in, q_out;
    logic [CW-1:0]   b_mid_x, b_mid_y, b_adx, b_ady;

    logic [CNT_OW-1:0] count;
    logic              found, ovf;
    logic [MX_OW-1:0]  mx;
    logic [MY_OW-1:0]  my;
    logic [LEN_OW-1:0] len;
    logic [ANG_OW-1:0] ang;

    lsss_front #(.CW(CW)) u_front (
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_x_start     (s_axis_tdata[CW-1:0]),
        .i_y_start     (s_axis_tdata[2*CW-1:CW]),
        .i_x_end       (s_axis_tdata[3*CW-1:2*CW]),
        .i_y_end       (s_axis_tdata[4*CW-1:3*CW]),
        .i_has_segment (s_axis_tuser),
        .i_last        (s_axis_tlast),
        .i_full        (full),
        .o_push        (push),
        .o_mid_x       (f_mid_x),
        .o_mid_y       (f_mid_y),
        .o_adx         (f_adx),
        .o_ady         (f_ady),
        .o_flags       (f_flags)
    );

    assign q_in = {f_flags, f_mid_x, f_mid_y, f_adx, f_ady};

    lsss_fifo #(.DW(QW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (q_out)
    );

    assign {b_flags, b_mid_x, b_mid_y, b_adx, b_ady} = q_out;

    lsss_back #(
        .CW           (CW),
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .o_pop         (pop),
        .i_mid_x       (b_mid_x),
        .i_mid_y       (b_mid_y),
        .i_adx         (b_adx),
        .i_ady         (b_ady),
        .i_flags       (b_flags),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_count       (count),
        .o_found       (found),
        .o_mean_mid_x  (mx),
        .o_mean_mid_y  (my),
        .o_mean_length (len),
        .o_mean_angle  (ang),
        .o_overflowed  (ovf)
    );

    assign m_axis_tdata = {ang, len, my, mx, count};
    assign m_axis_tuser = {ovf, found};

endmodule

// ===== sv/lsss_checker.sv =====
// ----------------------------------------------------------------------------
// lsss_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [71:0] i_data,
    input logic [1:0]  i_user
);
    import lsss_pkg::*;

    `ASSERT_NEXT(a_valid_holds, i_clk, i_rst_n, i_valid && !i_ready, i_valid)
    `ASSERT_NEXT(a_word_holds, i_clk, i_rst_n, i_valid && !i_ready, $stable(i_data) && $stable(i_user))
    `ASSERT_IMPLY(a_found_count, i_clk, i_rst_n, i_valid, i_user[0] == (i_data[10:0] != 11'd0))
    `ASSERT_IMPLY(a_empty_means, i_clk, i_rst_n, i_valid && !i_user[0], i_data[71:11] == 61'd0)

endmodule

bind line_segment_set_statistics lsss_checker u_lsss_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (m_axis_tvalid),
    .i_ready (m_axis_tready),
    .i_data  (m_axis_tdata),
    .i_user  (m_axis_tuser)
);
